>>> rtl/core/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, constants and the arctangent table for the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

	localparam int QW     = 16;  // quaternion component width, Q1.14
	localparam int PROD_W = 32;  // product of two components, Q28
	localparam int OPND_W = 34;  // arctangent operands, Q28 with headroom
	localparam int S_W    = 30;  // clamped arcsine argument
	localparam int NUM_W  = 57;  // radicand 2^56 - s*s
	localparam int ROOT_W = 29;  // square root of the radicand
	localparam int VEC_W  = 37;  // CORDIC vector width, covers the gain
	localparam int ANG_W  = 21;  // angle in Q16 radians
	localparam int STEPS  = 16;  // CORDIC iterations

	localparam logic signed [OPND_W-1:0] ONE_Q28 = OPND_W'(1) <<< 28;
	localparam logic signed [ANG_W-1:0]  PI_Q16  = ANG_W'(205887);
	localparam logic signed [14:0]       SCALE   = 15'(5730);

	// atan(2^-i) in Q16, rounded to nearest.
	function automatic logic signed [ANG_W-1:0] atan_tab(input int i);
		logic signed [ANG_W-1:0] t;
		unique case (i)
			0:  t = ANG_W'(51472);
			1:  t = ANG_W'(30386);
			2:  t = ANG_W'(16055);
			3:  t = ANG_W'(8150);
			4:  t = ANG_W'(4091);
			5:  t = ANG_W'(2047);
			6:  t = ANG_W'(1024);
			7:  t = ANG_W'(512);
			8:  t = ANG_W'(256);
			9:  t = ANG_W'(128);
			10: t = ANG_W'(64);
			11: t = ANG_W'(32);
			12: t = ANG_W'(16);
			13: t = ANG_W'(8);
			14: t = ANG_W'(4);
			default: t = ANG_W'(2);
		endcase
		return t;
	endfunction

endpackage

>>> rtl/core/q2e_isqrt.sv
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pipelined floor square root, one result bit per stage, with a sideband
// word that travels along with each item.
// ----------------------------------------------------------------------------
module q2e_isqrt #(
	parameter int SIDE_W = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [q2e_pkg::NUM_W-1:0]     num,
	input  logic [SIDE_W-1:0]             side_in,
	output logic                          out_valid,
	output logic [q2e_pkg::ROOT_W-1:0]    root,
	output logic [SIDE_W-1:0]             side_out
);

	localparam int NS  = q2e_pkg::ROOT_W;
	localparam int PW  = 2 * NS;
	localparam int RW  = NS + 2;

	logic              vld_s  [0:NS];
	logic [RW-1:0]     rem_s  [0:NS];
	logic [NS-1:0]     root_s [0:NS];
	logic [PW-1:0]     num_s  [0:NS];
	logic [SIDE_W-1:0] side_s [0:NS];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign num_s[0]  = PW'(num);
	assign side_s[0] = side_in;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		assign cur   = {rem_s[k], num_s[k][PW-1 -: 2]};
		assign trial = (RW+2)'({root_s[k], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1]  <= num_s[k] << 2;
				side_s[k+1] <= side_s[k];
				if (cur >= trial) begin
					rem_s[k+1]  <= RW'(cur - trial);
					root_s[k+1] <= {root_s[k][NS-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= RW'(cur);
					root_s[k+1] <= {root_s[k][NS-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[NS];
	assign root      = root_s[NS];
	assign side_out  = side_s[NS];

endmodule

>>> rtl/core/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC atan2 with conversion to hundredths of a degree.
// ----------------------------------------------------------------------------
module q2e_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [q2e_pkg::OPND_W-1:0]   yv,
	input  logic signed [q2e_pkg::OPND_W-1:0]   xv,
	output logic                                out_valid,
	output logic signed [15:0]                  angle
);

	localparam int VW = q2e_pkg::VEC_W;
	localparam int AW = q2e_pkg::ANG_W;
	localparam int NS = q2e_pkg::STEPS;
	localparam int MW = AW + 15;

	logic                 vld_s  [0:NS];
	logic signed [VW-1:0] x_s    [0:NS];
	logic signed [VW-1:0] y_s    [0:NS];
	logic signed [AW-1:0] ang_s  [0:NS];
	logic                 zero_s [0:NS];

	logic signed [VW-1:0] xe;
	logic signed [VW-1:0] ye;
	assign xe = VW'(xv);
	assign ye = VW'(yv);

	// Pre-rotation: a vector in the left half plane is turned by half a circle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (xv == '0) && (yv == '0);
			if (xv < 0) begin
				x_s[0]   <= -xe;
				y_s[0]   <= -ye;
				ang_s[0] <= (yv >= 0) ? q2e_pkg::PI_Q16 : -q2e_pkg::PI_Q16;
			end else begin
				x_s[0]   <= xe;
				y_s[0]   <= ye;
				ang_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1]   <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1]   <= y_s[i] - (x_s[i] >>> i);
					ang_s[i+1] <= ang_s[i] + q2e_pkg::atan_tab(i);
				end else begin
					x_s[i+1]   <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1]   <= y_s[i] + (x_s[i] >>> i);
					ang_s[i+1] <= ang_s[i] - q2e_pkg::atan_tab(i);
				end
			end
		end
	end

	// Scale to hundredths of a degree, then round half up.
	logic signed [MW-1:0] prod_sc;
	logic signed [MW-1:0] rnd;
	logic                 vld_sc;
	logic                 vld_out;
	logic signed [15:0]   angle_out;

	assign rnd = prod_sc + MW'(32768);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sc  <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			vld_sc  <= vld_s[NS];
			vld_out <= vld_sc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_sc   <= zero_s[NS] ? '0 : MW'(ang_s[NS]) * MW'(q2e_pkg::SCALE);
			angle_out <= rnd[31:16];
		end
	end

	assign out_valid = vld_out;
	assign angle     = angle_out;

endmodule

>>> rtl/core/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// Throughput: one quaternion per cycle; the whole pipeline advances together
// and holds while a finished result waits at the output.
// Reset: arst_n clears every valid bit at once; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts a Q1.14 attitude quaternion into roll, pitch and yaw in hundredths
// of a degree using exact products, a pipelined square root and three
// pipelined CORDIC arctangent units.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31]
);

	localparam int PW = q2e_pkg::PROD_W;
	localparam int OW = q2e_pkg::OPND_W;
	localparam int SW = q2e_pkg::S_W;
	localparam int NW = q2e_pkg::NUM_W;
	localparam int SIDE_W = SW + 4 * OW;

	// The pipeline moves as one: every stage advances when the output is
	// empty or its result is being taken in this cycle.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	assign quat_w = s_tdata[15:0];
	assign quat_x = s_tdata[31:16];
	assign quat_y = s_tdata[47:32];
	assign quat_z = s_tdata[63:48];

	// Stage 1: all component products, exact in Q28.
	logic                 vld_s1;
	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, xy_s1, wz_s1, zz_s1, wy_s1, xz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			xy_s1 <= quat_x * quat_y;
			wz_s1 <= quat_w * quat_z;
			zz_s1 <= quat_z * quat_z;
			wy_s1 <= quat_w * quat_y;
			xz_s1 <= quat_x * quat_z;
		end
	end

	// Stage 2: arctangent operands and the clamped arcsine argument.
	logic signed [OW-1:0] rn_c, rd_c, yn_c, yd_c, sraw_c;
	logic signed [SW-1:0] s_c;

	always_comb begin
		rn_c   = (OW'(yz_s1) + OW'(wx_s1)) <<< 1;
		rd_c   = q2e_pkg::ONE_Q28 - ((OW'(xx_s1) + OW'(yy_s1)) <<< 1);
		yn_c   = (OW'(xy_s1) + OW'(wz_s1)) <<< 1;
		yd_c   = q2e_pkg::ONE_Q28 - ((OW'(yy_s1) + OW'(zz_s1)) <<< 1);
		sraw_c = (OW'(wy_s1) - OW'(xz_s1)) <<< 1;
		priority if (sraw_c > q2e_pkg::ONE_Q28) begin
			s_c = SW'(q2e_pkg::ONE_Q28);
		end else if (sraw_c < -q2e_pkg::ONE_Q28) begin
			s_c = SW'(-q2e_pkg::ONE_Q28);
		end else begin
			s_c = SW'(sraw_c);
		end
	end

	logic                 vld_s2;
	logic signed [OW-1:0] rn_s2, rd_s2, yn_s2, yd_s2;
	logic signed [SW-1:0] s_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rn_s2 <= rn_c;
			rd_s2 <= rd_c;
			yn_s2 <= yn_c;
			yd_s2 <= yd_c;
			s_s2  <= s_c;
		end
	end

	// Stage 3: radicand 2^56 - s*s for the cosine of pitch.
	logic signed [2*SW-1:0] sq_c;
	assign sq_c = s_s2 * s_s2;

	logic                 vld_s3;
	logic signed [OW-1:0] rn_s3, rd_s3, yn_s3, yd_s3;
	logic signed [SW-1:0] s_s3;
	logic [NW-1:0]        num_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rn_s3  <= rn_s2;
			rd_s3  <= rd_s2;
			yn_s3  <= yn_s2;
			yd_s3  <= yd_s2;
			s_s3   <= s_s2;
			num_s3 <= (NW'(1) << (NW - 1)) - NW'(sq_c);
		end
	end

	// Square root; the other operands ride along to stay aligned.
	logic                           vld_sq;
	logic [q2e_pkg::ROOT_W-1:0]     c_sq;
	logic [SIDE_W-1:0]              side_sq;

	q2e_isqrt #(
		.SIDE_W (SIDE_W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.num       (num_s3),
		.side_in   ({s_s3, rn_s3, rd_s3, yn_s3, yd_s3}),
		.out_valid (vld_sq),
		.root      (c_sq),
		.side_out  (side_sq)
	);

	logic signed [SW-1:0] s_sq;
	logic signed [OW-1:0] rn_sq, rd_sq, yn_sq, yd_sq;
	assign {s_sq, rn_sq, rd_sq, yn_sq, yd_sq} = side_sq;

	// Three arctangent units of equal latency.
	logic               vld_roll, vld_pitch, vld_yaw;
	logic signed [15:0] roll_a, pitch_a, yaw_a;

	q2e_cordic u_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_sq),
		.yv        (rn_sq),
		.xv        (rd_sq),
		.out_valid (vld_roll),
		.angle     (roll_a)
	);

	q2e_cordic u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_sq),
		.yv        (OW'(s_sq)),
		.xv        (OW'(signed'({1'b0, c_sq}))),
		.out_valid (vld_pitch),
		.angle     (pitch_a)
	);

	q2e_cordic u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_sq),
		.yv        (yn_sq),
		.xv        (yd_sq),
		.out_valid (vld_yaw),
		.angle     (yaw_a)
	);

	// All three units see the same valid stream, so any one marks the result.
	assign m_tvalid = vld_roll & vld_pitch & vld_yaw;
	assign m_tdata  = {1'b0, yaw_a, pitch_a[14:0], roll_a};

endmodule
